>>> rtl/core/drc_pkg.sv
// ----------------------------------------------------------------------------
// drc_pkg
// Shared codes, register indexes and reset values for the deadband change
// reporter.
// ----------------------------------------------------------------------------
package drc_pkg;

    // report kinds
    localparam logic [1:0] KIND_THERMAL  = 2'd0;
    localparam logic [1:0] KIND_PRESSURE = 2'd1;
    localparam logic [1:0] KIND_HUMIDITY = 2'd2;
    localparam logic [1:0] KIND_NOMINAL  = 2'd3;

    // comfort classes
    localparam logic [2:0] COMFORT_OK    = 3'd0;
    localparam logic [2:0] COMFORT_WARM  = 3'd1;
    localparam logic [2:0] COMFORT_COOL  = 3'd2;
    localparam logic [2:0] COMFORT_HUMID = 3'd3;
    localparam logic [2:0] COMFORT_DRY   = 3'd4;

    // fixed confidence per kind, percent
    localparam logic [6:0] CONF_THERMAL  = 7'd88;
    localparam logic [6:0] CONF_PRESSURE = 7'd80;
    localparam logic [6:0] CONF_HUMIDITY = 7'd75;
    localparam logic [6:0] CONF_NOMINAL  = 7'd70;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_THR  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HUM_THR   = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRES_THR  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HEARTBEAT = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CT_LOW    = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CT_HIGH   = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CH_LOW    = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_CH_HIGH   = 4'd7;

    // register reset values
    localparam logic        [13:0] RST_TEMP_THR  = 14'd50;
    localparam logic        [13:0] RST_HUM_THR   = 14'd300;
    localparam logic        [16:0] RST_PRES_THR  = 17'd100;
    localparam logic        [31:0] RST_HEARTBEAT = 32'd300000;
    localparam logic signed [14:0] RST_CT_LOW    = 15'sd1800;
    localparam logic signed [14:0] RST_CT_HIGH   = 15'sd2600;
    localparam logic        [13:0] RST_CH_LOW    = 14'd3000;
    localparam logic        [13:0] RST_CH_HIGH   = 14'd6500;

    // control state of the two pipeline registers
    typedef struct packed {
        logic in_valid;
        logic out_valid;
    } pipe_state_t;

endpackage

>>> rtl/core/deadband_change_reporter_core.sv
// ----------------------------------------------------------------------------
// deadband_change_reporter_core
// Report-by-exception on environmental readings: deadband change reports for
// temperature, pressure and humidity, and a heartbeat nominal report with a
// comfort class.
// ----------------------------------------------------------------------------
//  channel | signals                          | beat
//  --------+----------------------------------+--------------------------------
//  in      | in_valid / in_stall + 4 fields   | one reading
//  out     | out_valid / out_stall + 9 fields | one report (zero or one/reading)
//  cfg     | cfg_we, cfg_index, cfg_data      | one register write
//
//  A reading is held in an input register, evaluated combinationally against
//  the stored previous reading, and its report lands in the result register;
//  while out_stall is low, one reading per cycle is sustained. Readings that
//  cause no report still update the previous reading.
//  in_stall rises only when the input register is full and the result register
//  holds a report that is stalled.
//  Reset (rst_n low, async) empties both registers and restores registers.
// ----------------------------------------------------------------------------
module deadband_change_reporter_core
    import drc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic signed [14:0]     temperature,
    input  logic [13:0]            humidity,
    input  logic [16:0]            pressure,
    input  logic [31:0]            now_ms,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             report_kind,
    output logic                   rising,
    output logic signed [17:0]     change_amount,
    output logic [2:0]             comfort_class,
    output logic [6:0]             confidence_pct,
    output logic signed [14:0]     temp_echo,
    output logic [13:0]            hum_echo,
    output logic [16:0]            pres_echo,
    output logic [31:0]            sequence_res
);

    // configuration
    logic        [13:0] temp_thr_reg;
    logic        [13:0] hum_thr_reg;
    logic        [16:0] pres_thr_reg;
    logic        [31:0] heartbeat_reg;
    logic signed [14:0] ct_low_reg;
    logic signed [14:0] ct_high_reg;
    logic        [13:0] ch_low_reg;
    logic        [13:0] ch_high_reg;

    // pipeline control
    pipe_state_t pipe_reg;
    pipe_state_t pipe_next;
    logic        advance;
    logic        in_load;

    // input register
    logic signed [14:0] t_reg;
    logic        [13:0] h_reg;
    logic        [16:0] p_reg;
    logic        [31:0] now_reg;

    // history
    logic signed [14:0] last_t_reg;
    logic        [13:0] last_h_reg;
    logic        [16:0] last_p_reg;
    logic               have_prev_reg;
    logic        [31:0] last_time_reg;
    logic        [31:0] count_reg;

    // result register
    logic        [1:0]  kind_reg;
    logic        [1:0]  kind_next;
    logic               rising_reg;
    logic signed [17:0] delta_reg;
    logic signed [17:0] delta_next;
    logic        [2:0]  comfort_reg;
    logic        [2:0]  comfort_next;
    logic        [6:0]  conf_reg;
    logic        [6:0]  conf_next;
    logic signed [14:0] t_echo_reg;
    logic        [13:0] h_echo_reg;
    logic        [16:0] p_echo_reg;

    // evaluation
    logic signed [15:0] dt;
    logic signed [14:0] dh;
    logic signed [17:0] dp;
    logic        [15:0] dt_mag;
    logic        [14:0] dh_mag;
    logic        [17:0] dp_mag;
    logic               first;
    logic               beat;
    logic               report;
    logic               t_ok;
    logic               h_ok;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign advance  = pipe_reg.in_valid && (!pipe_reg.out_valid || !out_stall);
    assign in_stall = pipe_reg.in_valid && !advance;
    assign in_load  = in_valid && !in_stall;

    always_comb
    begin
        pipe_next = pipe_reg;
        if (in_load)
            pipe_next.in_valid = 1'b1;
        else if (advance)
            pipe_next.in_valid = 1'b0;
        if (advance)
            pipe_next.out_valid = report;
        else if (pipe_reg.out_valid && !out_stall)
            pipe_next.out_valid = 1'b0;
    end

    // ------------------------------------------------------------------
    // evaluation of the held reading
    // ------------------------------------------------------------------
    assign dt = {t_reg[14], t_reg} - {last_t_reg[14], last_t_reg};
    assign dh = $signed({1'b0, h_reg}) - $signed({1'b0, last_h_reg});
    assign dp = $signed({1'b0, p_reg}) - $signed({1'b0, last_p_reg});

    assign dt_mag = dt[15] ? 16'(-dt) : 16'(dt);
    assign dh_mag = dh[14] ? 15'(-dh) : 15'(dh);
    assign dp_mag = dp[17] ? 18'(-dp) : 18'(dp);

    assign first = !have_prev_reg;
    assign beat  = (now_reg - last_time_reg) >= heartbeat_reg;

    assign t_ok = (t_reg >= ct_low_reg) && (t_reg <= ct_high_reg);
    assign h_ok = (h_reg >= ch_low_reg) && (h_reg <= ch_high_reg);

    always_comb
    begin
        report       = 1'b1;
        kind_next    = KIND_NOMINAL;
        delta_next   = '0;
        conf_next    = CONF_NOMINAL;
        comfort_next = COMFORT_OK;
        priority if (!first && dt_mag >= {2'b00, temp_thr_reg})
        begin
            kind_next  = KIND_THERMAL;
            delta_next = 18'(dt);
            conf_next  = CONF_THERMAL;
        end
        else if (!first && dp_mag >= {1'b0, pres_thr_reg})
        begin
            kind_next  = KIND_PRESSURE;
            delta_next = dp;
            conf_next  = CONF_PRESSURE;
        end
        else if (!first && dh_mag >= {1'b0, hum_thr_reg})
        begin
            kind_next  = KIND_HUMIDITY;
            delta_next = 18'(dh);
            conf_next  = CONF_HUMIDITY;
        end
        else if (first || beat)
        begin
            priority if (t_ok && h_ok)
                comfort_next = COMFORT_OK;
            else if (t_reg > ct_high_reg)
                comfort_next = COMFORT_WARM;
            else if (t_reg < ct_low_reg)
                comfort_next = COMFORT_COOL;
            else if (h_reg > ch_high_reg)
                comfort_next = COMFORT_HUMID;
            else
                comfort_next = COMFORT_DRY;
        end
        else
        begin
            report = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_thr_reg  <= RST_TEMP_THR;
            hum_thr_reg   <= RST_HUM_THR;
            pres_thr_reg  <= RST_PRES_THR;
            heartbeat_reg <= RST_HEARTBEAT;
            ct_low_reg    <= RST_CT_LOW;
            ct_high_reg   <= RST_CT_HIGH;
            ch_low_reg    <= RST_CH_LOW;
            ch_high_reg   <= RST_CH_HIGH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TEMP_THR:  temp_thr_reg  <= cfg_data[13:0];
                REG_HUM_THR:   hum_thr_reg   <= cfg_data[13:0];
                REG_PRES_THR:  pres_thr_reg  <= cfg_data[16:0];
                REG_HEARTBEAT: heartbeat_reg <= cfg_data[31:0];
                REG_CT_LOW:    ct_low_reg    <= $signed(cfg_data[14:0]);
                REG_CT_HIGH:   ct_high_reg   <= $signed(cfg_data[14:0]);
                REG_CH_LOW:    ch_low_reg    <= cfg_data[13:0];
                REG_CH_HIGH:   ch_high_reg   <= cfg_data[13:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_reg      <= '0;
            last_t_reg    <= '0;
            last_h_reg    <= '0;
            last_p_reg    <= '0;
            have_prev_reg <= 1'b0;
            last_time_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            pipe_reg <= pipe_next;
            if (advance)
            begin
                last_t_reg    <= t_reg;
                last_h_reg    <= h_reg;
                last_p_reg    <= p_reg;
                have_prev_reg <= 1'b1;
                if (report)
                begin
                    last_time_reg <= now_reg;
                    count_reg     <= count_reg + 32'd1;
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            t_reg   <= temperature;
            h_reg   <= humidity;
            p_reg   <= pressure;
            now_reg <= now_ms;
        end
        if (advance && report)
        begin
            kind_reg    <= kind_next;
            rising_reg  <= !delta_next[17] && (delta_next != '0);
            delta_reg   <= delta_next;
            comfort_reg <= comfort_next;
            conf_reg    <= conf_next;
            t_echo_reg  <= t_reg;
            h_echo_reg  <= h_reg;
            p_echo_reg  <= p_reg;
        end
    end

    // count_reg already holds the post-increment value once the beat is out
    assign out_valid      = pipe_reg.out_valid;
    assign report_kind    = kind_reg;
    assign rising         = rising_reg;
    assign change_amount  = delta_reg;
    assign comfort_class  = comfort_reg;
    assign confidence_pct = conf_reg;
    assign temp_echo      = t_echo_reg;
    assign hum_echo       = h_echo_reg;
    assign pres_echo      = p_echo_reg;
    assign sequence_res   = count_reg;

endmodule

>>> rtl/core/drc_checker.sv
// ----------------------------------------------------------------------------
// drc_checker
// Port-level checks on the report channel of the deadband change reporter.
// ----------------------------------------------------------------------------
module drc_checker
    import drc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         report_kind,
    input logic               rising,
    input logic signed [17:0] change_amount,
    input logic [2:0]         comfort_class,
    input logic [31:0]        sequence_res
);

    // a stalled report keeps its beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sequence_res))
        else $error("stalled report changed");

    // back-to-back reports carry consecutive sequence numbers
    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) ##1 (out_valid && !out_stall)
        |-> sequence_res == $past(sequence_res) + 32'd1)
        else $error("sequence gap between consecutive reports");

    // nominal reports carry no change
    a_nominal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_kind == KIND_NOMINAL |-> change_amount == '0 && !rising)
        else $error("nominal report with nonzero change");

    // change reports: comfortable class, rising follows the sign
    a_change: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_kind != KIND_NOMINAL
        |-> comfort_class == COMFORT_OK && rising == (change_amount > 0))
        else $error("change report fields inconsistent");

endmodule

bind deadband_change_reporter_core drc_checker u_drc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .report_kind   (report_kind),
    .rising        (rising),
    .change_amount (change_amount),
    .comfort_class (comfort_class),
    .sequence_res  (sequence_res)
);

>>> dv/drc_report_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drc_report_checker
// Watches the config port and both channels of the deadband change reporter.
// Keeps its own copy of the registers and the previous reading, works out the
// report that each accepted reading should cause, and compares every accepted
// report beat with the oldest one still due.
// ----------------------------------------------------------------------------
module drc_report_checker
    import drc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic signed [14:0]     temperature,
    input  logic [13:0]            humidity,
    input  logic [16:0]            pressure,
    input  logic [31:0]            now_ms,

    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [1:0]             report_kind,
    input  logic                   rising,
    input  logic signed [17:0]     change_amount,
    input  logic [2:0]             comfort_class,
    input  logic [6:0]             confidence_pct,
    input  logic signed [14:0]     temp_echo,
    input  logic [13:0]            hum_echo,
    input  logic [16:0]            pres_echo,
    input  logic [31:0]            sequence_res,

    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        logic [1:0]         kind;
        logic               rise;
        logic signed [17:0] amount;
        logic [2:0]         comfort;
        logic [6:0]         conf;
        logic signed [14:0] temp;
        logic [13:0]        hum;
        logic [16:0]        pres;
        logic [31:0]        seq;
    } report_t;

    // register copy
    logic [13:0]        temp_thr;
    logic [13:0]        hum_thr;
    logic [16:0]        pres_thr;
    logic [31:0]        heartbeat;
    logic signed [14:0] ct_low;
    logic signed [14:0] ct_high;
    logic [13:0]        ch_low;
    logic [13:0]        ch_high;

    // previous reading and report bookkeeping
    logic signed [14:0] prev_temp;
    logic [13:0]        prev_hum;
    logic [16:0]        prev_pres;
    logic               seen_reading;
    logic [31:0]        last_report_ms;
    logic [31:0]        report_total;

    report_t due_reports[$];

    function automatic logic [31:0] magnitude(input int d);
        return (d < 0) ? -d : d;
    endfunction

    function automatic logic [2:0] comfort_of_reading(input logic signed [14:0] t,
                                                      input logic [13:0] h);
        logic t_ok;
        logic h_ok;
        t_ok = (t >= ct_low) && (t <= ct_high);
        h_ok = (h >= ch_low) && (h <= ch_high);
        if (t_ok && h_ok) return COMFORT_OK;
        if (t > ct_high) return COMFORT_WARM;
        if (t < ct_low) return COMFORT_COOL;
        if (h > ch_high) return COMFORT_HUMID;
        return COMFORT_DRY;
    endfunction

    // Updates the previous reading; returns 1 when the reading causes a report.
    function automatic bit evaluate_reading(input logic signed [14:0] t,
                                            input logic [13:0] h,
                                            input logic [16:0] p,
                                            input logic [31:0] now,
                                            output report_t rpt);
        int          dt;
        int          dh;
        int          dp;
        logic [31:0] elapsed;
        bit          fires;
        dt      = int'(t) - int'(prev_temp);
        dh      = int'(h) - int'(prev_hum);
        dp      = int'(p) - int'(prev_pres);
        elapsed = now - last_report_ms;
        rpt     = '0;
        fires   = 1'b1;
        if (seen_reading && magnitude(dt) >= temp_thr) begin
            rpt.kind   = KIND_THERMAL;
            rpt.amount = dt[17:0];
            rpt.rise   = dt > 0;
            rpt.conf   = CONF_THERMAL;
        end else if (seen_reading && magnitude(dp) >= pres_thr) begin
            rpt.kind   = KIND_PRESSURE;
            rpt.amount = dp[17:0];
            rpt.rise   = dp > 0;
            rpt.conf   = CONF_PRESSURE;
        end else if (seen_reading && magnitude(dh) >= hum_thr) begin
            rpt.kind   = KIND_HUMIDITY;
            rpt.amount = dh[17:0];
            rpt.rise   = dh > 0;
            rpt.conf   = CONF_HUMIDITY;
        end else if (!seen_reading || elapsed >= heartbeat) begin
            rpt.kind    = KIND_NOMINAL;
            rpt.conf    = CONF_NOMINAL;
            rpt.comfort = comfort_of_reading(t, h);
        end else begin
            fires = 1'b0;
        end
        if (fires) begin
            report_total   = report_total + 1;
            last_report_ms = now;
            rpt.temp       = t;
            rpt.hum        = h;
            rpt.pres       = p;
            rpt.seq        = report_total;
        end
        prev_temp    = t;
        prev_hum     = h;
        prev_pres    = p;
        seen_reading = 1'b1;
        return fires;
    endfunction

    always @(posedge clk or negedge rst_n) begin : monitor
        report_t seen;
        report_t want;
        if (!rst_n) begin
            temp_thr       = RST_TEMP_THR;
            hum_thr        = RST_HUM_THR;
            pres_thr       = RST_PRES_THR;
            heartbeat      = RST_HEARTBEAT;
            ct_low         = RST_CT_LOW;
            ct_high        = RST_CT_HIGH;
            ch_low         = RST_CH_LOW;
            ch_high        = RST_CH_HIGH;
            prev_temp      = '0;
            prev_hum       = '0;
            prev_pres      = '0;
            seen_reading   = 1'b0;
            last_report_ms = '0;
            report_total   = '0;
            due_reports.delete();
            pending        = 0;
        end else begin
            // output beat first: a reading accepted this edge cannot have reported yet
            if (out_valid && !out_stall) begin
                seen = '{report_kind, rising, change_amount, comfort_class, confidence_pct,
                         temp_echo, hum_echo, pres_echo, sequence_res};
                if (due_reports.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: report beat with none due: kind=%0d seq=%0d",
                                 $realtime, seen.kind, seen.seq);
                    fail_count = fail_count + 1;
                end else begin
                    want = due_reports.pop_front();
                    if (seen !== want) begin
                        if (fail_count < 10) begin
                            $display("%0t: report mismatch", $realtime);
                            $display("  exp kind=%0d rise=%0b amt=%0d cls=%0d conf=%0d t=%0d h=%0d p=%0d seq=%0d",
                                     want.kind, want.rise, $signed(want.amount), want.comfort,
                                     want.conf, $signed(want.temp), want.hum, want.pres, want.seq);
                            $display("  got kind=%0d rise=%0b amt=%0d cls=%0d conf=%0d t=%0d h=%0d p=%0d seq=%0d",
                                     seen.kind, seen.rise, $signed(seen.amount), seen.comfort,
                                     seen.conf, $signed(seen.temp), seen.hum, seen.pres, seen.seq);
                        end
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall) begin
                if (evaluate_reading(temperature, humidity, pressure, now_ms, want))
                    due_reports.push_back(want);
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_TEMP_THR:  temp_thr  = cfg_data[13:0];
                    REG_HUM_THR:   hum_thr   = cfg_data[13:0];
                    REG_PRES_THR:  pres_thr  = cfg_data[16:0];
                    REG_HEARTBEAT: heartbeat = cfg_data;
                    REG_CT_LOW:    ct_low    = cfg_data[14:0];
                    REG_CT_HIGH:   ct_high   = cfg_data[14:0];
                    REG_CH_LOW:    ch_low    = cfg_data[13:0];
                    REG_CH_HIGH:   ch_high   = cfg_data[13:0];
                    default: ;
                endcase
            end
            pending = due_reports.size();
        end
    end

endmodule

>>> dv/deadband_change_reporter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadband_change_reporter_core_tb
// Drives readings into the deadband change reporter: a directed opening that
// walks every report kind, the thresholds, heartbeat wrap and the comfort
// classes, then random drifting readings over several register settings and
// idle/stall mixes. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module deadband_change_reporter_core_tb;
    import drc_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int NUM_REGS        = 8;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 115;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic signed [14:0]     temperature;
    logic [13:0]            humidity;
    logic [16:0]            pressure;
    logic [31:0]            now_ms;
    logic                   out_valid;
    logic                   out_stall;
    logic [1:0]             report_kind;
    logic                   rising;
    logic signed [17:0]     change_amount;
    logic [2:0]             comfort_class;
    logic [6:0]             confidence_pct;
    logic signed [14:0]     temp_echo;
    logic [13:0]            hum_echo;
    logic [16:0]            pres_echo;
    logic [31:0]            sequence_res;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycles        = 0;

    deadband_change_reporter_core i_dut (.*);

    drc_report_checker i_checker (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99, 0) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_reading(input logic signed [14:0] t, input logic [13:0] h,
                                input logic [16:0] p, input logic [31:0] ms);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        temperature <= t;
        humidity    <= h;
        pressure    <= p;
        now_ms      <= ms;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0]        regs [NUM_REGS];
        logic [31:0]        clock_ms;
        logic [31:0]        noise;
        logic signed [14:0] rt;
        logic [13:0]        rh;
        logic [16:0]        rp;
        int                 walk_t;
        int                 walk_h;
        int                 walk_p;
        int                 pick;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        temperature = '0;
        humidity    = '0;
        pressure    = '0;
        now_ms      = '0;

        regs[REG_TEMP_THR]  = 32'(RST_TEMP_THR);
        regs[REG_HUM_THR]   = 32'(RST_HUM_THR);
        regs[REG_PRES_THR]  = 32'(RST_PRES_THR);
        regs[REG_HEARTBEAT] = RST_HEARTBEAT;
        regs[REG_CT_LOW]    = 32'(RST_CT_LOW);
        regs[REG_CT_HIGH]   = 32'(RST_CT_HIGH);
        regs[REG_CH_LOW]    = 32'(RST_CH_LOW);
        regs[REG_CH_HIGH]   = 32'(RST_CH_HIGH);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening at reset settings
        send_reading(2000, 4000, 101325, 0);          // first reading -> nominal
        send_reading(2000, 4000, 101325, 10);         // unchanged -> nothing
        send_reading(2050, 4000, 101325, 20);         // temp exactly at threshold
        send_reading(2001, 4000, 101325, 30);         // just below
        send_reading(1950, 4000, 101325, 40);         // falling thermal
        send_reading(1950, 4300, 101425, 50);         // pressure wins over humidity
        send_reading(1950, 4000, 101425, 60);         // falling humidity
        send_reading(2500, 7000, 90000, 70);          // all three move -> thermal
        send_reading(2500, 7000, 90000, 300069);      // one ms short of heartbeat
        send_reading(2500, 7000, 90000, 300070);      // heartbeat, humid
        send_reading(8500, 7000, 90000, 300080);
        send_reading(8500, 7000, 90000, 600080);      // warm
        send_reading(-4000, 0, 30000, 600090);
        send_reading(-4000, 0, 30000, 900090);        // cool
        send_reading(2000, 0, 30000, 900100);
        send_reading(2000, 0, 30000, 1200100);        // dry
        send_reading(2000, 10000, 110000, 1200110);
        send_reading(-16384, 16383, 131071, 1200120); // full-width fields
        send_reading(16383, 0, 0, 1200130);
        send_reading(16383, 0, 131071, 1200140);      // widest pressure swing
        send_reading(16383, 0, 0, 32'hFFFF_FFF0);
        send_reading(16383, 0, 0, 32'h0004_93D0);     // heartbeat across timestamp wrap
        send_reading(16383, 16383, 0, 32'h0004_93DA);
        clock_ms = 32'h0004_93DA;
        walk_t   = 2000;
        walk_h   = 5000;
        walk_p   = 100000;

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                in_valid <= 1'b0;
                wait_drained();
                case (phase)
                    1:
                    begin
                        // zero thresholds, heartbeat every reading
                        regs[REG_TEMP_THR]  = 0;
                        regs[REG_HUM_THR]   = 0;
                        regs[REG_PRES_THR]  = 0;
                        regs[REG_HEARTBEAT] = 0;
                    end
                    2:
                    begin
                        regs[REG_TEMP_THR]  = 12500;
                        regs[REG_HUM_THR]   = 10000;
                        regs[REG_PRES_THR]  = 80000;
                        regs[REG_HEARTBEAT] = 32'hFFFF_FFFF;
                        regs[REG_CT_LOW]    = -4000;
                        regs[REG_CT_HIGH]   = 8500;
                        regs[REG_CH_LOW]    = 0;
                        regs[REG_CH_HIGH]   = 10000;
                    end
                    3:
                    begin
                        // comfort bounds inverted
                        regs[REG_TEMP_THR]  = 100;
                        regs[REG_HUM_THR]   = 500;
                        regs[REG_PRES_THR]  = 200;
                        regs[REG_HEARTBEAT] = 5000;
                        regs[REG_CT_LOW]    = 2600;
                        regs[REG_CT_HIGH]   = 1800;
                        regs[REG_CH_LOW]    = 6500;
                        regs[REG_CH_HIGH]   = 3000;
                    end
                    4:
                    begin
                        regs[REG_TEMP_THR]  = $urandom_range(12500, 0);
                        regs[REG_HUM_THR]   = $urandom_range(10000, 0);
                        regs[REG_PRES_THR]  = $urandom_range(80000, 0);
                        regs[REG_HEARTBEAT] = $urandom_range(20000, 0);
                        regs[REG_CT_LOW]    = int'($urandom_range(12500, 0)) - 4000;
                        regs[REG_CT_HIGH]   = int'($urandom_range(12500, 0)) - 4000;
                        regs[REG_CH_LOW]    = $urandom_range(10000, 0);
                        regs[REG_CH_HIGH]   = $urandom_range(10000, 0);
                    end
                    5:
                    begin
                        // raw 32-bit data; the block keeps only the low bits
                        for (int r = 0; r < NUM_REGS; r++)
                            regs[r] = $urandom();
                    end
                    default:
                    begin
                        regs[REG_TEMP_THR]  = 1;
                        regs[REG_HUM_THR]   = 1;
                        regs[REG_PRES_THR]  = 1;
                        regs[REG_HEARTBEAT] = 1;
                        regs[REG_CT_LOW]    = 8500;
                        regs[REG_CT_HIGH]   = -4000;
                        regs[REG_CH_LOW]    = 10000;
                        regs[REG_CH_HIGH]   = 0;
                    end
                endcase
                for (int r = 0; r < NUM_REGS; r++)
                begin
                    cfg_we    <= 1'b1;
                    cfg_index <= r[CFG_INDEX_W-1:0];
                    cfg_data  <= regs[r];
                    @(posedge clk);
                end
                // unmapped index must be ignored
                noise      = $urandom_range(2 ** CFG_INDEX_W - 1, NUM_REGS);
                cfg_index <= noise[CFG_INDEX_W-1:0];
                cfg_data  <= $urandom();
                @(posedge clk);
                cfg_we <= 1'b0;
            end

            case (phase % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 78; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 78; end
                default: begin send_idle_pct = 38; stall_pct = 38; end
            endcase

            repeat (ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 70)
                begin
                    walk_t += int'($urandom_range(160, 0)) - 80;
                    walk_h += int'($urandom_range(800, 0)) - 400;
                    walk_p += int'($urandom_range(300, 0)) - 150;
                end
                else if (pick < 85)
                begin
                    walk_t = int'($urandom_range(12500, 0)) - 4000;
                    walk_h = $urandom_range(10000, 0);
                    walk_p = $urandom_range(110000, 30000);
                end
                if (walk_t < -4000) walk_t = -4000;
                if (walk_t > 8500) walk_t = 8500;
                if (walk_h < 0) walk_h = 0;
                if (walk_h > 10000) walk_h = 10000;
                if (walk_p < 30000) walk_p = 30000;
                if (walk_p > 110000) walk_p = 110000;
                rt = walk_t[14:0];
                rh = walk_h[13:0];
                rp = walk_p[16:0];
                if (pick >= 90)
                begin
                    // out-of-range noise over the full field widths
                    noise = $urandom();
                    rt    = noise[14:0];
                    rh    = noise[28:15];
                    noise = $urandom();
                    rp    = noise[16:0];
                end

                pick = $urandom_range(99, 0);
                if (pick < 70)
                    clock_ms += $urandom_range(3000, 0);
                else if (pick < 90)
                    clock_ms += regs[REG_HEARTBEAT] + $urandom_range(2, 0) - 1;
                else
                    clock_ms += $urandom();

                send_reading(rt, rh, rp, clock_ms);
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> deadband_change_reporter_core.f
rtl/core/drc_pkg.sv
rtl/core/deadband_change_reporter_core.sv
rtl/core/drc_checker.sv
dv/drc_report_checker.sv
dv/deadband_change_reporter_core_tb.sv
